FILE: rtl/xrr_pkg.sv
// ----------------------------------------------------------------------------
// xrr_pkg
// Types, constants and the xorshift step shared by the ranged random core.
// ----------------------------------------------------------------------------
package xrr_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CntW   = $clog2(WordW);
  localparam int unsigned ShiftA = 13;
  localparam int unsigned ShiftB = 17;
  localparam int unsigned ShiftC = 5;

  localparam logic ActReseed = 1'b0;
  localparam logic ActDraw   = 1'b1;

  typedef struct packed {
    logic                    action;
    logic [WordW-1:0]        seed;
    logic signed [WordW-1:0] minimum;
    logic signed [WordW-1:0] maximum;
  } xrr_in_t;

  typedef struct packed {
    logic [WordW-1:0]        raw_value;
    logic signed [WordW-1:0] ranged_value;
  } xrr_out_t;

  function automatic logic [WordW-1:0] xs_advance(input logic [WordW-1:0] x);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    a = x ^ (x << ShiftA);
    b = a ^ (a >> ShiftB);
    return b ^ (b << ShiftC);
  endfunction

endpackage

FILE: rtl/xorshift_ranged_random_core.sv
// ----------------------------------------------------------------------------
// xorshift_ranged_random_core
// 32-bit xorshift generator with reseed and ranged draw transactions.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A reseed, or a draw whose range
// maximum - minimum is zero or negative, goes from input accept straight to
// the output state. A draw over a non-empty range first passes the divide
// state: the remainder |word| mod delta is formed by a bit-serial divider
// that retires one dividend bit per cycle. A new input is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
module xorshift_ranged_random_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xrr_pkg::xrr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xrr_pkg::xrr_out_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_e;

  state_e                           state_q;
  logic [xrr_pkg::WordW-1:0]        word_q, word_d;
  logic signed [xrr_pkg::WordW-1:0] min_q;
  logic signed [xrr_pkg::WordW-1:0] ranged_q;
  logic                             out_valid_q;
  xrr_pkg::xrr_out_t                out_q;

  logic                      in_acc;
  logic                      is_draw;
  logic [xrr_pkg::WordW-1:0] delta, mag, rem;
  logic                      empty;
  logic                      div_start, div_done;
  logic                      out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_draw    = (in_data_i.action == xrr_pkg::ActDraw);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    if (is_draw) begin
      word_d = xrr_pkg::xs_advance(word_q);
    end else if (in_data_i.seed == '0) begin
      word_d = xrr_pkg::WordW'(1);
    end else begin
      word_d = in_data_i.seed;
    end
  end

  assign delta     = $unsigned(in_data_i.maximum) - $unsigned(in_data_i.minimum);
  assign empty     = (delta == '0) || delta[xrr_pkg::WordW-1];
  assign mag       = word_d[xrr_pkg::WordW-1] ? ('0 - word_d) : word_d;
  assign div_start = in_acc && is_draw && !empty;

  xrr_remainder u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (delta),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      word_q      <= xrr_pkg::WordW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            word_q  <= word_d;
            state_q <= div_start ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      min_q    <= in_data_i.minimum;
      ranged_q <= is_draw ? in_data_i.minimum : '0;
    end
    if (state_q == S_DIV && div_done) begin
      ranged_q <= $signed($unsigned(min_q) + rem);
    end
    if (state_q == S_OUT && out_free) begin
      out_q.raw_value    <= word_q;
      out_q.ranged_value <= ranged_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_word_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q != '0) else $error("generator word is zero");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV)) else $error("divider done outside divide");

  a_start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == S_DIV)) else $error("divide not entered");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("output loaded outside output state");

endmodule

FILE: rtl/xrr_remainder.sv
// ----------------------------------------------------------------------------
// xrr_remainder
// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module xrr_remainder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [xrr_pkg::WordW-1:0]  dividend_i,
  input  logic [xrr_pkg::WordW-1:0]  divisor_i,
  output logic                       done_o,
  output logic [xrr_pkg::WordW-1:0]  rem_o
);

  localparam logic [xrr_pkg::CntW-1:0] CntLast = xrr_pkg::CntW'(xrr_pkg::WordW - 1);

  logic [xrr_pkg::WordW-1:0] dvd_q, dsr_q, rem_q;
  logic [xrr_pkg::WordW-1:0] trial, diff;
  logic [xrr_pkg::CntW-1:0]  cnt_q;
  logic                      busy_q, done_q;
  logic                      geq;

  assign trial = {rem_q[xrr_pkg::WordW-2:0], dvd_q[xrr_pkg::WordW-1]};
  assign geq   = (trial >= dsr_q);
  assign diff  = trial - dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= geq ? diff : trial;
      dvd_q <= {dvd_q[xrr_pkg::WordW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("remainder restarted while busy");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dsr_q)) else $error("remainder not below divisor");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for xorshift_ranged_random_core.
// Drives reseed and draw transactions with random gaps and output stalls.
// A local generator model predicts the raw word and the ranged value of
// every transaction, and each output transaction is checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int StallLimit = 2000;
  localparam int DrainCycles = 60;
  localparam int RandomItems = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  xrr_pkg::xrr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  xrr_pkg::xrr_out_t out_data_o;

  xrr_pkg::xrr_in_t stim_q[$];
  xrr_pkg::xrr_out_t due_q[$];
  logic [31:0] gen_word;
  int err_count = 0;
  int in_wait = 0;
  int in_calm = 0;
  int out_wait = 0;
  int out_calm = 0;
  int stall_cycles = 0;

  xorshift_ranged_random_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] xorshift_step(logic [31:0] w);
    w = w ^ (w << xrr_pkg::ShiftA);
    w = w ^ (w >> xrr_pkg::ShiftB);
    w = w ^ (w << xrr_pkg::ShiftC);
    return w;
  endfunction

  // Seed that makes the next draw land on the given word.
  function automatic logic [31:0] xorshift_back(logic [31:0] y);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = y;
    repeat (7) a = y ^ (a << xrr_pkg::ShiftC);
    b = a;
    repeat (2) b = a ^ (b >> xrr_pkg::ShiftB);
    c = b;
    repeat (3) c = b ^ (c << xrr_pkg::ShiftA);
    return c;
  endfunction

  function automatic logic [31:0] fit_range(logic [31:0] word, logic [31:0] lo,
                                            logic [31:0] hi);
    logic [31:0] delta;
    logic [31:0] mag;
    delta = hi - lo;
    if (delta == 32'd0 || delta[31]) begin
      return lo;
    end
    mag = word[31] ? 32'd0 - word : word;
    return lo + (mag % delta);
  endfunction

  function automatic xrr_pkg::xrr_out_t apply_item(xrr_pkg::xrr_in_t it);
    xrr_pkg::xrr_out_t r;
    if (it.action == xrr_pkg::ActReseed) begin
      gen_word = (it.seed == 32'd0) ? 32'd1 : it.seed;
      r.ranged_value = '0;
    end else begin
      gen_word = xorshift_step(gen_word);
      r.ranged_value = fit_range(gen_word, it.minimum, it.maximum);
    end
    r.raw_value = gen_word;
    return r;
  endfunction

  function automatic xrr_pkg::xrr_in_t make_item(logic act, logic [31:0] seed,
                                                 logic [31:0] lo, logic [31:0] hi);
    xrr_pkg::xrr_in_t it;
    it.action = act;
    it.seed = seed;
    it.minimum = lo;
    it.maximum = hi;
    return it;
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(8, 40);
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch on %s: got %h, want %h", field, got, want);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic nxt_valid;
    xrr_pkg::xrr_in_t nxt_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gen_word = 32'd1;
      in_wait = draw_wait(in_calm);
    end else begin
      nxt_valid = in_valid_i;
      nxt_data = in_data_i;
      if (in_valid_i && in_ready_o) begin
        due_q.push_back(apply_item(in_data_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (stim_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data = stim_q.pop_front();
          in_wait = draw_wait(in_calm);
        end
      end
      in_valid_i <= nxt_valid;
      in_data_i <= nxt_data;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic nxt_ready;
    xrr_pkg::xrr_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_wait = draw_wait(out_calm);
    end else begin
      nxt_ready = out_ready_i;
      if (out_valid_o && out_ready_i) begin
        if (due_q.size() == 0) begin
          report("unexpected transaction", out_data_o.raw_value, 32'd0);
        end else begin
          want = due_q.pop_front();
          if (out_data_o.raw_value !== want.raw_value) begin
            report("raw_value", out_data_o.raw_value, want.raw_value);
          end
          if (out_data_o.ranged_value !== want.ranged_value) begin
            report("ranged_value", out_data_o.ranged_value, want.ranged_value);
          end
        end
        nxt_ready = 1'b0;
        out_wait = draw_wait(out_calm);
      end
      if (!nxt_ready) begin
        if (out_wait > 0) begin
          out_wait--;
        end else begin
          nxt_ready = 1'b1;
        end
      end
      out_ready_i <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int kind;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] edges[4];
    edges[0] = 32'h8000_0000;
    edges[1] = 32'h7FFF_FFFF;
    edges[2] = 32'h0000_0000;
    edges[3] = 32'hFFFF_FFFF;

    // directed: field extremes and range corner cases
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'd0, 32'd10));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, 32'h0, 32'h0, 32'h0));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'hFFFF_FFFF, 32'd5, 32'd5));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'd100, -32'sd100));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'h0, 32'h7FFF_FFFF));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'h8000_0000, 32'h8000_0001));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, 32'hFFFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, -32'sd7, 32'sd7));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, xorshift_back(32'h8000_0000), 0, 0));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'd0, 32'd3));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, xorshift_back(32'h8000_0000), 0, 0));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'h7FFF_FFF0, 32'hFFFF_FFEF));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, xorshift_back(32'h7FFF_FFFE), 0, 0));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'h7FFF_FFF0, 32'hFFFF_FFEF));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, 32'h8000_0000, 0, 0));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'h8000_0000, 32'h0));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, 32'h7FFF_FFFF, 0, 0));
    stim_q.push_back(make_item(xrr_pkg::ActReseed, 32'hAAAA_AAAA, 0, 0));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h5555_5555, 32'h5555_5555,
                               32'h7FFF_FFFF));
    stim_q.push_back(make_item(xrr_pkg::ActDraw, 32'h0, 32'hFFFF_FFFF, 32'h0));

    for (int i = 0; i < RandomItems; i++) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        stim_q.push_back(make_item(xrr_pkg::ActReseed,
                                   ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom,
                                   $urandom, $urandom));
      end else begin
        kind = $urandom_range(0, 5);
        case (kind)
          0: begin
            lo = $urandom_range(0, 2000) - 1000;
            hi = lo + $urandom_range(1, 64);
          end
          1: begin
            lo = $urandom;
            hi = $urandom;
          end
          2: begin
            lo = $urandom;
            hi = lo - $urandom_range(0, 1000);
          end
          3: begin
            lo = $urandom;
            hi = lo + (32'd1 << $urandom_range(0, 30));
          end
          4: begin
            lo = edges[$urandom_range(0, 3)];
            hi = edges[$urandom_range(0, 3)];
          end
          default: begin
            lo = $urandom;
            hi = lo + $urandom_range(1, 32'h7FFF_FFFF);
          end
        endcase
        stim_q.push_back(make_item(xrr_pkg::ActDraw, $urandom, lo, hi));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (stim_q.size() > 0 || in_valid_i || due_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: xorshift_ranged_random_core.f
rtl/xrr_pkg.sv
rtl/xrr_remainder.sv
rtl/xorshift_ranged_random_core.sv
sim/tb.sv
